// ===== src/jfad_pkg.sv =====
package jfad_pkg;

    // Angle accumulator format: signed Q12.16 degrees
    localparam int ZW = 28;
    localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

    // Product and rotator widths
    localparam int MW = 33;
    localparam int XW = 36;

    // Number of rotation steps, multiply schedule length and square-root steps
    localparam int CORD_STEPS = 23;
    localparam int MUL_STEPS  = 13;
    localparam int SQRT_STEPS = 32;

    // Register indexes
    localparam logic [2:0] REG_FIRST  = 3'd0;
    localparam logic [2:0] REG_JOINT  = 3'd1;
    localparam logic [2:0] REG_END    = 3'd2;
    localparam logic [2:0] REG_THRESH = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;
    localparam logic [2:0] REG_DIR    = 3'd5;

    // Compare modes
    localparam logic [1:0] MODE_BELOW = 2'd0;
    localparam logic [1:0] MODE_ABOVE = 2'd1;
    localparam logic [1:0] MODE_EQUAL = 2'd2;

    // Direction checks
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_BELOW = 2'd1;
    localparam logic [1:0] DIR_ABOVE = 2'd2;

    // Result codes
    localparam logic [1:0] FLEX_NO        = 2'd0;
    localparam logic [1:0] FLEX_YES       = 2'd1;
    localparam logic [1:0] FLEX_UNDECIDED = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic red;
        logic mul;
        logic sq_init;
        logic sq_step;
        logic cset;
        logic cnorm;
        logic crd;
        logic fin;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic degen;
        logic red_done;
        logic norm_done;
    } t_stat;

    // atan(2^-i) in degrees, Q12.16, rounded
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = ZW'(2949120);
            5'd1:  v = ZW'(1740967);
            5'd2:  v = ZW'(919879);
            5'd3:  v = ZW'(466945);
            5'd4:  v = ZW'(234379);
            5'd5:  v = ZW'(117304);
            5'd6:  v = ZW'(58666);
            5'd7:  v = ZW'(29335);
            5'd8:  v = ZW'(14668);
            5'd9:  v = ZW'(7334);
            5'd10: v = ZW'(3667);
            5'd11: v = ZW'(1833);
            5'd12: v = ZW'(917);
            5'd13: v = ZW'(458);
            5'd14: v = ZW'(229);
            5'd15: v = ZW'(115);
            5'd16: v = ZW'(57);
            5'd17: v = ZW'(29);
            5'd18: v = ZW'(14);
            5'd19: v = ZW'(7);
            5'd20: v = ZW'(4);
            5'd21: v = ZW'(2);
            5'd22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/jfad_datapath.sv =====
module jfad_datapath import jfad_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  t_cmd                          i_cmd,
    input  logic [4:0]                    i_step,
    input  logic signed [COORD_WIDTH-1:0] i_pts [9],
    input  logic [7:0]                    i_thr,
    input  logic [1:0]                    i_mode,
    input  logic [1:0]                    i_dir,
    output t_stat                         o_stat,
    output logic [1:0]                    o_flex_result,
    output logic [15:0]                   o_angle_q8,
    output logic                          o_degenerate
);

    localparam int DW = COORD_WIDTH + 1;

    // Vector magnitudes and signs
    logic [DW-1:0]            r_m1 [3];
    logic [DW-1:0]            r_m2 [3];
    logic [2:0]               r_s1, r_s2;
    logic                     r_degen, r_jlt, r_jgt;
    logic signed [DW-1:0]     d1 [3];
    logic signed [DW-1:0]     d2 [3];
    logic                     big1, big2;
    logic signed [15:0]       a1 [3];
    logic signed [15:0]       a2 [3];
    logic signed [15:0]       ext1 [3];
    logic signed [15:0]       ext2 [3];

    // Products
    logic signed [MW-1:0]     op_a, op_b;
    logic signed [2*MW-1:0]   prod;
    logic signed [63:0]       r_prod;
    logic signed [MW-1:0]     plo;
    logic signed [MW-1:0]     r_dot, r_tmp, r_cx, r_cy, r_cz;
    logic [63:0]              r_sq;

    // Square root
    logic [63:0]              r_n, r_r, r_b;
    logic [64:0]              sq_sum;

    // Rotator
    logic signed [XW-1:0]     r_x, r_y, ymag;
    logic signed [ZW-1:0]     r_z, zc;
    logic [ZW-1:0]            zr;
    logic                     r_czero;
    logic                     cbig;

    // Result
    logic [15:0]              ang;
    logic                     comp;
    logic [1:0]               res;

    // Difference vectors from the point store
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1[k] = DW'(i_pts[k]) - DW'(i_pts[3 + k]);
            d2[k] = DW'(i_pts[6 + k]) - DW'(i_pts[3 + k]);
        end
    end

    // Reduced components as 16-bit signed
    always_comb begin
        big1 = 1'b0;
        big2 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            big1 = big1 | (|r_m1[k][DW-1:15]);
            big2 = big2 | (|r_m2[k][DW-1:15]);
            ext1[k] = {1'b0, r_m1[k][14:0]};
            ext2[k] = {1'b0, r_m2[k][14:0]};
            a1[k] = r_s1[k] ? 16'(-ext1[k]) : ext1[k];
            a2[k] = r_s2[k] ? 16'(-ext2[k]) : ext2[k];
        end
    end

    // Load, then shift each vector down one bit a cycle until it fits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_s1[k] <= d1[k][DW-1];
                r_s2[k] <= d2[k][DW-1];
                r_m1[k] <= d1[k][DW-1] ? DW'(-d1[k]) : DW'(d1[k]);
                r_m2[k] <= d2[k][DW-1] ? DW'(-d2[k]) : DW'(d2[k]);
            end
            r_degen <= (d1[0] == '0 && d1[1] == '0 && d1[2] == '0) ||
                       (d2[0] == '0 && d2[1] == '0 && d2[2] == '0);
            r_jlt <= i_pts[4] < i_pts[7];
            r_jgt <= i_pts[4] > i_pts[7];
        end else if (i_cmd.red) begin
            for (int k = 0; k < 3; k++) begin
                if (big1) begin
                    r_m1[k] <= r_m1[k] >> 1;
                end
                if (big2) begin
                    r_m2[k] <= r_m2[k] >> 1;
                end
            end
        end
    end

    // Multiply operand schedule: dot, cross terms, then squares
    always_comb begin
        case (i_step)
            5'd0:  begin op_a = MW'(a1[0]); op_b = MW'(a2[0]); end
            5'd1:  begin op_a = MW'(a1[1]); op_b = MW'(a2[1]); end
            5'd2:  begin op_a = MW'(a1[2]); op_b = MW'(a2[2]); end
            5'd3:  begin op_a = MW'(a1[1]); op_b = MW'(a2[2]); end
            5'd4:  begin op_a = MW'(a1[2]); op_b = MW'(a2[1]); end
            5'd5:  begin op_a = MW'(a1[2]); op_b = MW'(a2[0]); end
            5'd6:  begin op_a = MW'(a1[0]); op_b = MW'(a2[2]); end
            5'd7:  begin op_a = MW'(a1[0]); op_b = MW'(a2[1]); end
            5'd8:  begin op_a = MW'(a1[1]); op_b = MW'(a2[0]); end
            5'd9:  begin op_a = r_cx; op_b = r_cx; end
            5'd10: begin op_a = r_cy; op_b = r_cy; end
            5'd11: begin op_a = r_cz; op_b = r_cz; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        prod = op_a * op_b;
        plo  = r_prod[MW-1:0];
    end

    // Register each product, fold in the previous one
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= prod[63:0];
            case (i_step)
                5'd1:  r_dot <= plo;
                5'd2:  r_dot <= r_dot + plo;
                5'd3:  r_dot <= r_dot + plo;
                5'd4:  r_tmp <= plo;
                5'd5:  r_cx  <= r_tmp - plo;
                5'd6:  r_tmp <= plo;
                5'd7:  r_cy  <= r_tmp - plo;
                5'd8:  r_tmp <= plo;
                5'd9:  r_cz  <= r_tmp - plo;
                5'd10: r_sq  <= r_prod;
                5'd11: r_sq  <= r_sq + r_prod;
                5'd12: r_sq  <= r_sq + r_prod;
                default: r_tmp <= r_tmp;
            endcase
        end
    end

    // Integer square root, one result bit a cycle
    assign sq_sum = {1'b0, r_r} + {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_n <= r_sq;
            r_r <= '0;
            r_b <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sq_step) begin
            if ({1'b0, r_n} >= sq_sum) begin
                r_n <= r_n - sq_sum[63:0];
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    // Vectoring rotator for atan2(cross, dot)
    assign ymag = r_y[XW-1] ? -r_y : r_y;
    assign cbig = (|r_x[XW-1:30]) || (|r_y[XW-1:30]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cset) begin
            r_czero <= (r_dot == '0) && (r_r[32:0] == '0);
            if (r_dot[MW-1]) begin
                r_x <= XW'(r_r[32:0]);
                r_y <= -XW'(r_dot);
                r_z <= DEG90;
            end else begin
                r_x <= XW'(r_dot);
                r_y <= XW'(r_r[32:0]);
                r_z <= '0;
            end
        end else if (i_cmd.cnorm) begin
            if (!cbig && !r_czero) begin
                r_x <= r_x <<< 1;
                r_y <= r_y <<< 1;
            end
        end else if (i_cmd.crd) begin
            r_x <= r_x + (ymag >>> i_step);
            if (!r_y[XW-1]) begin
                r_y <= r_y - (r_x >>> i_step);
                r_z <= r_z + atan_q16(i_step);
            end else begin
                r_y <= r_y + (r_x >>> i_step);
                r_z <= r_z - atan_q16(i_step);
            end
        end
    end

    // Clamp, round to Q8.8, compare and check direction
    always_comb begin
        if (r_z < 0) begin
            zc = '0;
        end else if (r_z > DEG180) begin
            zc = DEG180;
        end else begin
            zc = r_z;
        end
        zr  = ZW'(zc) + ZW'(128);
        ang = r_czero ? 16'd0 : zr[23:8];
        case (i_mode)
            MODE_BELOW: comp = {i_thr, 8'd0} > ang;
            MODE_ABOVE: comp = {i_thr, 8'd0} < ang;
            MODE_EQUAL: comp = {i_thr, 8'd0} == ang;
            default:    comp = 1'b0;
        endcase
        res = FLEX_NO;
        if (comp) begin
            case (i_dir)
                DIR_NONE:  res = FLEX_YES;
                DIR_BELOW: res = r_jlt ? FLEX_YES : FLEX_NO;
                DIR_ABOVE: res = r_jgt ? FLEX_YES : FLEX_NO;
                default:   res = FLEX_UNDECIDED;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (r_degen) begin
                o_flex_result <= FLEX_NO;
                o_angle_q8    <= '0;
                o_degenerate  <= 1'b1;
            end else begin
                o_flex_result <= res;
                o_angle_q8    <= ang;
                o_degenerate  <= 1'b0;
            end
        end
    end

    assign o_stat.degen     = r_degen;
    assign o_stat.red_done  = !big1 && !big2;
    assign o_stat.norm_done = cbig || r_czero;

endmodule

// ===== src/jfad_ctrl.sv =====
module jfad_ctrl import jfad_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_trig,
    input  logic       i_stall,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic [4:0] o_step,
    output logic       o_stall,
    output logic       o_valid
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_RED   = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_SQI   = 10'b0000010000,
        S_SQRT  = 10'b0000100000,
        S_CSET  = 10'b0001000000,
        S_CNORM = 10'b0010000000,
        S_CORD  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_oval, n_oval;

    // Next state, step counter and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        n_oval  = r_oval && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_accept && i_trig) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RED;
            end
            S_RED: begin
                if (i_stat.degen) begin
                    n_state = S_FIN;
                end else if (i_stat.red_done) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end else begin
                    o_cmd.red = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_cnt == 5'(MUL_STEPS - 1)) begin
                    n_state = S_SQI;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SQI: begin
                o_cmd.sq_init = 1'b1;
                n_cnt         = '0;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                    n_state = S_CSET;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_CSET: begin
                o_cmd.cset = 1'b1;
                n_state    = S_CNORM;
            end
            S_CNORM: begin
                if (i_stat.norm_done) begin
                    n_state = S_CORD;
                    n_cnt   = '0;
                end else begin
                    o_cmd.cnorm = 1'b1;
                end
            end
            S_CORD: begin
                o_cmd.crd = 1'b1;
                if (r_cnt == 5'(CORD_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_FIN: begin
                if (!r_oval || !i_stall) begin
                    o_cmd.fin = 1'b1;
                    n_oval    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
        end
    end

    assign o_step  = r_cnt;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;

endmodule

// ===== src/joint_flexion_angle_detector.sv =====
// Joint flexion angle detector. Keeps the latest position of three configured
// tracker sensors (first, joint, end); a report for one of them, once all
// three have been seen, yields one beat with the angle at the joint in Q8.8
// degrees, the threshold verdict and a zero-length flag. Other reports yield
// nothing. A report that yields a result holds the input through loading,
// one-bit vector scaling, the single shared multiplier, the bit-serial
// square root, normalizing, 23 rotator steps and the step that registers the
// result, which waits while the output is stalled; a zero-length vector goes
// from scaling straight to registering the result. A finished result waits in
// the output register while the next report is taken.
module joint_flexion_angle_detector import jfad_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int ID_WIDTH    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_addr,
    input  logic [7:0]                    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ID_WIDTH-1:0]           i_sensor_id,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_flex_result,
    output logic [15:0]                   o_angle_q8,
    output logic                          o_degenerate
);

    localparam int IDX = (ID_WIDTH > 8) ? ID_WIDTH : 8;

    logic [7:0]                    r_ids [3];
    logic [7:0]                    r_thr;
    logic [1:0]                    r_mode, r_dir;
    logic [2:0]                    r_seen;
    logic signed [COORD_WIDTH-1:0] r_pts [9];
    logic [IDX-1:0]                id_ext [3];
    logic [2:0]                    hit;
    logic                          accept, trig;
    t_cmd                          cmd;
    t_stat                         stat;
    logic [4:0]                    step;

    assign accept = i_valid && !o_stall;

    // Match the report against the configured ids
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            id_ext[k] = IDX'(r_ids[k]);
            hit[k]    = (id_ext[k][ID_WIDTH-1:0] == i_sensor_id);
        end
    end

    assign trig = (|hit) && ((r_seen | hit) == 3'b111);

    // Configuration registers and seen flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids[0] <= 8'd0;
            r_ids[1] <= 8'd1;
            r_ids[2] <= 8'd2;
            r_thr    <= 8'd90;
            r_mode   <= MODE_BELOW;
            r_dir    <= DIR_NONE;
            r_seen   <= '0;
        end else begin
            if (accept) begin
                r_seen <= r_seen | hit;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_FIRST: begin
                        r_ids[0]  <= i_cfg_wdata;
                        r_seen[0] <= 1'b0;
                    end
                    REG_JOINT: begin
                        r_ids[1]  <= i_cfg_wdata;
                        r_seen[1] <= 1'b0;
                    end
                    REG_END: begin
                        r_ids[2]  <= i_cfg_wdata;
                        r_seen[2] <= 1'b0;
                    end
                    REG_THRESH: r_thr  <= i_cfg_wdata;
                    REG_MODE:   r_mode <= i_cfg_wdata[1:0];
                    REG_DIR:    r_dir  <= i_cfg_wdata[1:0];
                    default:    r_thr  <= r_thr;
                endcase
            end
        end
    end

    // Point store: overwrite every slot whose id matches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_pts[k] <= '0;
            end
        end else if (accept) begin
            for (int k = 0; k < 3; k++) begin
                if (hit[k]) begin
                    r_pts[3 * k]     <= i_pos_x;
                    r_pts[3 * k + 1] <= i_pos_y;
                    r_pts[3 * k + 2] <= i_pos_z;
                end
            end
        end
    end

    jfad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_trig   (trig),
        .i_stall  (i_stall),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_step   (step),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    jfad_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_step        (step),
        .i_pts         (r_pts),
        .i_thr         (r_thr),
        .i_mode        (r_mode),
        .i_dir         (r_dir),
        .o_stat        (stat),
        .o_flex_result (o_flex_result),
        .o_angle_q8    (o_angle_q8),
        .o_degenerate  (o_degenerate)
    );

endmodule
